[hw/rtl/indexed_list_engine_top_defines.svh]
// ----------------------------------------------------------------------------
// Indexed list engine assertion macros
// Shared concurrent assertion forms, sampled on clk_i and off during reset.
// ----------------------------------------------------------------------------
`ifndef INDEXED_LIST_ENGINE_TOP_DEFINES_SVH
`define INDEXED_LIST_ENGINE_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ILE_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ILE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/ile_pkg.sv]
// ----------------------------------------------------------------------------
// Indexed list engine package
// Operation and status codes, cell modes and the command word sent to cells.
// ----------------------------------------------------------------------------
package ile_pkg;

  localparam int unsigned DataW = 32;

  typedef enum logic [2:0] {
    OP_READ       = 3'd0,
    OP_WRITE      = 3'd1,
    OP_PUSH_BACK  = 3'd2,
    OP_PUSH_FRONT = 3'd3,
    OP_POP_FRONT  = 3'd4,
    OP_INSERT     = 3'd5,
    OP_REMOVE     = 3'd6,
    OP_CLEAR      = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    MODE_HOLD  = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_OPEN  = 2'd2,
    MODE_CLOSE = 2'd3
  } cell_mode_e;

  typedef struct packed {
    cell_mode_e        mode;
    logic [DataW-1:0]  value;
  } cell_cmd_t;

endpackage

[hw/rtl/ile_cell.sv]
// ----------------------------------------------------------------------------
// Indexed list engine cell
// Holds one list word and loads, keeps or takes a neighbour's word each cycle.
// ----------------------------------------------------------------------------
module ile_cell import ile_pkg::*; #(
  parameter int unsigned IdxW = 6
) (
  input  logic             clk_i,
  input  logic [IdxW-1:0]  idx_i,
  input  logic [IdxW-1:0]  pos_i,
  input  logic [IdxW-1:0]  rd_pos_i,
  input  cell_cmd_t        cmd_i,
  input  logic [DataW-1:0] left_i,
  input  logic [DataW-1:0] right_i,
  output logic [DataW-1:0] data_o,
  output logic [DataW-1:0] rd_o
);

  logic [DataW-1:0] data_q;
  logic [DataW-1:0] data_d;
  logic             load;

  always_comb begin
    load   = 1'b0;
    data_d = data_q;
    case (cmd_i.mode)
      MODE_WRITE: begin
        if (idx_i == pos_i) begin
          load   = 1'b1;
          data_d = cmd_i.value;
        end
      end
      MODE_OPEN: begin
        if (idx_i == pos_i) begin
          load   = 1'b1;
          data_d = cmd_i.value;
        end else if (idx_i > pos_i) begin
          load   = 1'b1;
          data_d = left_i;
        end
      end
      MODE_CLOSE: begin
        if (idx_i >= pos_i) begin
          load   = 1'b1;
          data_d = right_i;
        end
      end
      default: begin
        load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= data_d;
    end
  end

  assign data_o = data_q;
  assign rd_o   = (idx_i == rd_pos_i) ? data_q : '0;

endmodule

[hw/rtl/indexed_list_engine_top.sv]
// The done_o strobe carrying the result word follows start_i in the next cycle.
// Throughput: one operation per cycle; busy_o stays low and every word is taken.
// Insert and remove shift all later cells along the cell chain.
// Reset clears the entry count and the result strobe; cell contents are not
// cleared and an entry is only read after it has been written.
// ----------------------------------------------------------------------------
// Indexed list engine top level
// Bounded ordered list of signed words held in a chain of shifting cells.
// ----------------------------------------------------------------------------
`include "indexed_list_engine_top_defines.svh"

module indexed_list_engine_top import ile_pkg::*; #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [2:0]  op_i,
  input  logic [5:0]  position_i,
  input  logic [31:0] value_i,
  output logic        done_o,
  output logic [31:0] read_data_o,
  output logic [1:0]  status_o,
  output logic [6:0]  count_o
);

  localparam int unsigned IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned LenW = $clog2(CAPACITY + 1);
  localparam int unsigned CmpW = (LenW > 6) ? LenW : 6;

  logic [LenW-1:0]  length_q, length_d;
  logic             done_q;
  logic [DataW-1:0] rdata_q, rdata_d;
  status_e          status_q, status_d;
  cell_cmd_t        cmd;
  logic [IdxW-1:0]  cmd_pos;
  logic [IdxW-1:0]  rd_pos;
  logic             accept, in_range, full, empty;
  logic [DataW-1:0] rd_any;

  logic [DataW-1:0] cell_data [CAPACITY];
  logic [DataW-1:0] cell_rd   [CAPACITY];

  assign busy_o   = 1'b0;
  assign accept   = start_i && !busy_o;
  assign in_range = CmpW'(position_i) < CmpW'(length_q);
  assign full     = length_q == LenW'(CAPACITY);
  assign empty    = length_q == '0;
  assign rd_pos   = IdxW'(position_i);

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DataW-1:0] left, right;
    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid_l
      assign left = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right = '0;
    end else begin : g_mid_r
      assign right = cell_data[i+1];
    end
    ile_cell #(
      .IdxW(IdxW)
    ) u_cell (
      .clk_i   (clk_i),
      .idx_i   (IdxW'(i)),
      .pos_i   (cmd_pos),
      .rd_pos_i(rd_pos),
      .cmd_i   (cmd),
      .left_i  (left),
      .right_i (right),
      .data_o  (cell_data[i]),
      .rd_o    (cell_rd[i])
    );
  end

  always_comb begin
    rd_any = '0;
    for (int unsigned k = 0; k < CAPACITY; k++) begin
      rd_any = rd_any | cell_rd[k];
    end
  end

  always_comb begin
    cmd.mode  = MODE_HOLD;
    cmd.value = value_i;
    cmd_pos   = IdxW'(position_i);
    length_d  = length_q;
    status_d  = ST_OK;
    rdata_d   = '0;
    if (accept) begin
      case (op_e'(op_i))
        OP_READ: begin
          if (in_range) begin
            rdata_d = rd_any;
          end else begin
            status_d = ST_RANGE;
          end
        end
        OP_WRITE: begin
          if (in_range) begin
            cmd.mode = MODE_WRITE;
          end else begin
            status_d = ST_RANGE;
          end
        end
        OP_PUSH_BACK: begin
          if (full) begin
            status_d = ST_FULL;
          end else begin
            cmd.mode = MODE_WRITE;
            cmd_pos  = IdxW'(length_q);
            length_d = length_q + 1'b1;
          end
        end
        OP_PUSH_FRONT: begin
          if (full) begin
            status_d = ST_FULL;
          end else begin
            cmd.mode = MODE_OPEN;
            cmd_pos  = '0;
            length_d = length_q + 1'b1;
          end
        end
        OP_POP_FRONT: begin
          if (empty) begin
            status_d = ST_EMPTY;
          end else begin
            cmd.mode = MODE_CLOSE;
            cmd_pos  = '0;
            length_d = length_q - 1'b1;
          end
        end
        OP_INSERT: begin
          if (!in_range) begin
            status_d = ST_RANGE;
          end else if (full) begin
            status_d = ST_FULL;
          end else begin
            cmd.mode = MODE_OPEN;
            length_d = length_q + 1'b1;
          end
        end
        OP_REMOVE: begin
          if (!in_range) begin
            status_d = ST_RANGE;
          end else begin
            cmd.mode = MODE_CLOSE;
            length_d = length_q - 1'b1;
          end
        end
        default: begin
          length_d = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      length_q <= '0;
      done_q   <= 1'b0;
    end else begin
      length_q <= length_d;
      done_q   <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q  <= rdata_d;
    status_q <= status_d;
  end

  assign done_o      = done_q;
  assign read_data_o = rdata_q;
  assign status_o    = status_q;
  assign count_o     = 7'(length_q);

  `ILE_ASSERT_NEXT(a_done_follows_start, accept, done_o, "Result word missing after a start.")
  `ILE_ASSERT_NEXT(a_no_spurious_done, !accept, !done_o, "Result word without a start.")
  `ILE_ASSERT_SAME(a_full_at_capacity, done_o && status_o == ST_FULL,
                   length_q == LenW'(CAPACITY), "Full status below capacity.")
  `ILE_ASSERT_SAME(a_refused_zero_data, done_o && status_o != ST_OK, read_data_o == '0,
                   "Refused operation returned data.")
  `ILE_ASSERT_SAME(a_length_bounded, 1'b1, length_q <= LenW'(CAPACITY),
                   "Entry count beyond capacity.")

endmodule
